[src/bwr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_pkg
// Codes, addresses and read masks for the banked work RAM and register map.
// ----------------------------------------------------------------------------
package bwr_pkg;

   // bus commands
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_SPEED = 2'd2;

   // machine modes
   localparam logic [1:0] MODE_MONO   = 2'd0;
   localparam logic [1:0] MODE_COLOUR = 2'd1;
   localparam logic [1:0] MODE_COMPAT = 2'd2;

   // configuration register indexes
   localparam logic CSR_MACHINE_MODE = 1'b0;
   localparam logic CSR_SKIP_BOOT    = 1'b1;

   // address map
   localparam logic [15:0] ADDR_WRAM_LO = 16'hC000;
   localparam logic [15:0] ADDR_WRAM_HI = 16'hFDFF;
   localparam logic [15:0] ADDR_HRAM_LO = 16'hFF80;
   localparam logic [15:0] ADDR_IE      = 16'hFFFF;
   localparam logic [15:0] ADDR_IF      = 16'hFF0F;
   localparam logic [15:0] ADDR_BOOT    = 16'hFF50;
   localparam logic [15:0] ADDR_IO_LO   = 16'hFF00;
   localparam logic [15:0] ADDR_IO_HI   = 16'hFF7F;
   localparam logic [15:0] ADDR_KEY1    = 16'hFF4D;
   localparam logic [15:0] ADDR_IR      = 16'hFF56;
   localparam logic [15:0] ADDR_PRIO    = 16'hFF6C;
   localparam logic [15:0] ADDR_BANK    = 16'hFF70;
   localparam logic [15:0] ADDR_SPARE0  = 16'hFF72;
   localparam logic [15:0] ADDR_SPARE1  = 16'hFF73;
   localparam logic [15:0] ADDR_SPARE2  = 16'hFF74;
   localparam logic [15:0] ADDR_SPARE3  = 16'hFF75;

   // fixed read masks
   localparam logic [7:0] MASK_IF_SET    = 8'hE0;
   localparam logic [7:0] MASK_KEY1_SET  = 8'h7E;
   localparam logic [7:0] MASK_IR_KEEP   = 8'hC1;
   localparam logic [7:0] MASK_IR_SET    = 8'h3C;
   localparam logic [7:0] MASK_IR_RX     = 8'hC0;
   localparam logic [7:0] MASK_PRIO_SET  = 8'hFE;
   localparam logic [7:0] MASK_BANK_SET  = 8'hF8;
   localparam logic [7:0] MASK_SPARE_SET = 8'h8F;
   localparam logic [7:0] IO_OPEN_BUS    = 8'hFF;

   // where the read byte of an item comes from
   typedef enum logic [1:0] {
      SRC_REG,
      SRC_WRAM,
      SRC_HRAM
   } rd_src_type;

endpackage

[src/banked_work_ram_io_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_work_ram_io_map
// Banked work RAM, high RAM and system register map behind one bus channel.
// ----------------------------------------------------------------------------
// A request passes the synchronous RAM read and pending register, then the
// response register. Throughput: one item per cycle while responses are
// taken; the work RAM and high RAM read ports set it. Reset: after reset a
// clearing pass zeroes the work RAM and high RAM one byte a cycle over all
// RAM_BANKS*4096 bytes (32768 by default); no request is taken until it ends.
module banked_work_ram_io_map
   import bwr_pkg::*;
#(
   parameter int RAM_BANKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_boot_overlay_active,
   output logic        rsp_double_speed_now,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [1:0]  csr_write_data
);

   localparam int WRAM_DEPTH = RAM_BANKS * 4096;
   localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
   localparam int BANK_W     = $clog2(RAM_BANKS);
   localparam int HRAM_DEPTH = 127;

   // memories
   logic [7:0] wram_mem [0:WRAM_DEPTH-1];
   logic [7:0] hram_mem [0:HRAM_DEPTH-1];
   logic [7:0] wram_rdata_ff;
   logic [7:0] hram_rdata_ff;

   // configuration and small state
   logic [1:0] mode_ff;
   logic       skip_boot_ff;
   logic [7:0] irq_enable_ff,   irq_enable_in;
   logic [4:0] irq_flags_ff,    irq_flags_in;
   logic [7:0] boot_flag_ff,    boot_flag_in;
   logic [2:0] bank_select_ff,  bank_select_in;
   logic       speed_armed_ff,  speed_armed_in;
   logic       double_speed_ff, double_speed_in;
   logic [7:0] infrared_ff,     infrared_in;
   logic       priority_ff,     priority_in;
   logic [7:0] spare0_ff,       spare0_in;
   logic [7:0] spare1_ff,       spare1_in;
   logic [7:0] spare2_ff,       spare2_in;
   logic [2:0] spare_high_ff,   spare_high_in;

   // clearing pass
   logic               clr_busy_ff;
   logic [WRAM_AW-1:0] clr_addr_ff;

   // pipeline
   logic       pend_valid_ff;
   rd_src_type pend_src_ff;
   logic [7:0] pend_data_ff;
   logic       pend_overlay_ff;
   logic       pend_speed_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_overlay_ff;
   logic       rsp_speed_ff;

   logic               req_fire;
   logic               pend_move;
   logic               is_read, is_write;
   logic               in_wram, in_hram, in_io;
   logic               colour_hw, colour_feat;
   logic [2:0]         upper_raw;
   logic [BANK_W-1:0]  upper_bank;
   logic [BANK_W-1:0]  bank_sel;
   logic [WRAM_AW-1:0] wram_idx;
   logic [6:0]         hram_idx;
   logic               wram_we, hram_we;
   logic [WRAM_AW-1:0] wram_waddr;
   logic [6:0]         hram_waddr;
   logic [7:0]         wram_wdata;
   logic [7:0]         reg_rdata;
   logic [7:0]         io_rdata;
   rd_src_type         src_in;
   logic [7:0]         boot_eff_in;
   logic [7:0]         pend_rdata;

   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!pend_valid_ff || pend_move);
   assign req_fire  = req_valid && req_ready;
   assign is_read   = (req_command == CMD_READ);
   assign is_write  = (req_command == CMD_WRITE);

   assign colour_hw   = (mode_ff == MODE_COLOUR) || (mode_ff == MODE_COMPAT);
   assign colour_feat = (mode_ff == MODE_COLOUR);

   assign in_wram = (req_address >= ADDR_WRAM_LO) && (req_address <= ADDR_WRAM_HI);
   assign in_hram = (req_address >= ADDR_HRAM_LO) && (req_address != ADDR_IE);
   assign in_io   = (req_address >= ADDR_IO_LO) && (req_address <= ADDR_IO_HI);

   // upper bank: select 0 means 1, fixed at 1 outside colour mode, saturates
   always_comb begin
      if (!colour_feat || bank_select_ff == 3'd0) begin
         upper_raw = 3'd1;
      end else begin
         upper_raw = bank_select_ff;
      end
      if ({1'b0, upper_raw} >= 4'(RAM_BANKS)) begin
         upper_bank = BANK_W'(RAM_BANKS - 1);
      end else begin
         upper_bank = BANK_W'(upper_raw);
      end
   end

   // echo region folds onto C000-DDFF through the low 13 address bits
   assign bank_sel = req_address[12] ? upper_bank : '0;
   assign wram_idx = WRAM_AW'({bank_sel, req_address[11:0]});
   assign hram_idx = req_address[6:0];

   // register reads in the IO page
   always_comb begin
      unique case (req_address)
         ADDR_KEY1:
            io_rdata = colour_hw ? ({double_speed_ff, 6'd0, speed_armed_ff} | MASK_KEY1_SET)
                                 : IO_OPEN_BUS;
         ADDR_IR:
            io_rdata = colour_feat ? ((infrared_ff & MASK_IR_KEEP) | MASK_IR_SET |
                          (((infrared_ff & MASK_IR_RX) == MASK_IR_RX) ? 8'h00 : 8'h02))
                                   : IO_OPEN_BUS;
         ADDR_PRIO:
            io_rdata = colour_feat ? ({7'd0, priority_ff} | MASK_PRIO_SET) : IO_OPEN_BUS;
         ADDR_BANK:
            io_rdata = colour_feat ? ({5'd0, bank_select_ff} | MASK_BANK_SET) : IO_OPEN_BUS;
         ADDR_SPARE0: io_rdata = colour_feat ? spare0_ff : IO_OPEN_BUS;
         ADDR_SPARE1: io_rdata = colour_feat ? spare1_ff : IO_OPEN_BUS;
         ADDR_SPARE2: io_rdata = colour_feat ? spare2_ff : IO_OPEN_BUS;
         ADDR_SPARE3:
            io_rdata = colour_feat ? ({1'b0, spare_high_ff, 4'd0} | MASK_SPARE_SET)
                                   : IO_OPEN_BUS;
         default:     io_rdata = IO_OPEN_BUS;
      endcase
   end

   // source and register byte of a read
   always_comb begin
      src_in    = SRC_REG;
      reg_rdata = 8'h00;
      if (is_read) begin
         if (in_wram) begin
            src_in = SRC_WRAM;
         end else if (in_hram) begin
            src_in = SRC_HRAM;
         end else if (req_address == ADDR_IE) begin
            reg_rdata = irq_enable_ff;
         end else if (req_address == ADDR_IF) begin
            reg_rdata = {3'd0, irq_flags_ff} | MASK_IF_SET;
         end else if (req_address == ADDR_BOOT) begin
            reg_rdata = skip_boot_ff ? 8'h01 : boot_flag_ff;
         end else if (in_io) begin
            reg_rdata = io_rdata;
         end
      end
   end

   // register updates of an accepted item
   always_comb begin
      irq_enable_in   = irq_enable_ff;
      irq_flags_in    = irq_flags_ff;
      boot_flag_in    = boot_flag_ff;
      bank_select_in  = bank_select_ff;
      speed_armed_in  = speed_armed_ff;
      double_speed_in = double_speed_ff;
      infrared_in     = infrared_ff;
      priority_in     = priority_ff;
      spare0_in       = spare0_ff;
      spare1_in       = spare1_ff;
      spare2_in       = spare2_ff;
      spare_high_in   = spare_high_ff;
      if (req_command == CMD_SPEED) begin
         double_speed_in = !double_speed_ff;
         speed_armed_in  = 1'b0;
      end else if (is_write && !in_wram && !in_hram) begin
         if (req_address == ADDR_IE) begin
            irq_enable_in = req_write_data;
         end else if (req_address == ADDR_IF) begin
            irq_flags_in = req_write_data[4:0];
         end else if (req_address == ADDR_BOOT) begin
            // set-once flag
            if (!skip_boot_ff && boot_flag_ff == 8'h00 && req_write_data != 8'h00) begin
               boot_flag_in = req_write_data;
            end
         end else if (in_io) begin
            unique case (req_address)
               ADDR_KEY1:   if (colour_hw)   speed_armed_in = req_write_data[0];
               ADDR_IR:     if (colour_feat) infrared_in    = req_write_data;
               ADDR_PRIO:   if (colour_feat) priority_in    = req_write_data[0];
               ADDR_BANK:   if (colour_feat) bank_select_in = req_write_data[2:0];
               ADDR_SPARE0: if (colour_feat) spare0_in      = req_write_data;
               ADDR_SPARE1: if (colour_feat) spare1_in      = req_write_data;
               ADDR_SPARE2: if (colour_feat) spare2_in      = req_write_data;
               ADDR_SPARE3: if (colour_feat) spare_high_in  = req_write_data[6:4];
               default: ;
            endcase
         end
      end
      boot_eff_in = skip_boot_ff ? 8'h01 : boot_flag_in;
   end

   // write ports: the clearing pass owns them until it ends
   always_comb begin
      if (clr_busy_ff) begin
         wram_we    = 1'b1;
         wram_waddr = clr_addr_ff;
         wram_wdata = 8'h00;
         hram_we    = (clr_addr_ff[6:0] != 7'h7F);
         hram_waddr = clr_addr_ff[6:0];
      end else begin
         wram_we    = req_fire && is_write && in_wram;
         wram_waddr = wram_idx;
         wram_wdata = req_write_data;
         hram_we    = req_fire && is_write && in_hram;
         hram_waddr = hram_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (wram_we) begin
         wram_mem[wram_waddr] <= wram_wdata;
      end
      if (req_fire && is_read && in_wram) begin
         wram_rdata_ff <= wram_mem[wram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (hram_we) begin
         hram_mem[hram_waddr] <= wram_wdata;
      end
      if (req_fire && is_read && in_hram) begin
         hram_rdata_ff <= hram_mem[hram_idx];
      end
   end

   always_comb begin
      case (pend_src_ff)
         SRC_WRAM: pend_rdata = wram_rdata_ff;
         SRC_HRAM: pend_rdata = hram_rdata_ff;
         default:  pend_rdata = pend_data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_MONO;
         skip_boot_ff    <= 1'b0;
         irq_enable_ff   <= '0;
         irq_flags_ff    <= '0;
         boot_flag_ff    <= '0;
         bank_select_ff  <= '0;
         speed_armed_ff  <= 1'b0;
         double_speed_ff <= 1'b0;
         infrared_ff     <= '0;
         priority_ff     <= 1'b0;
         spare0_ff       <= '0;
         spare1_ff       <= '0;
         spare2_ff       <= '0;
         spare_high_ff   <= '0;
         clr_busy_ff     <= 1'b1;
         clr_addr_ff     <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == WRAM_AW'(WRAM_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end

         if (req_fire) begin
            irq_enable_ff   <= irq_enable_in;
            irq_flags_ff    <= irq_flags_in;
            boot_flag_ff    <= boot_flag_in;
            bank_select_ff  <= bank_select_in;
            speed_armed_ff  <= speed_armed_in;
            double_speed_ff <= double_speed_in;
            infrared_ff     <= infrared_in;
            priority_ff     <= priority_in;
            spare0_ff       <= spare0_in;
            spare1_ff       <= spare1_in;
            spare2_ff       <= spare2_in;
            spare_high_ff   <= spare_high_in;
         end

         // the user writes configuration only while idle; the block does not enforce it
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MACHINE_MODE: begin
                  mode_ff <= csr_write_data;
                  if (csr_write_data != MODE_COLOUR && csr_write_data != MODE_COMPAT) begin
                     bank_select_ff  <= '0;
                     speed_armed_ff  <= 1'b0;
                     double_speed_ff <= 1'b0;
                  end
               end
               CSR_SKIP_BOOT: skip_boot_ff <= csr_write_data[0];
               default: ;
            endcase
         end

         if (req_fire) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end

         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_src_ff     <= src_in;
         pend_data_ff    <= reg_rdata;
         pend_overlay_ff <= (boot_eff_in == 8'h00);
         pend_speed_ff   <= double_speed_in;
      end
      if (pend_move) begin
         rsp_data_ff    <= pend_rdata;
         rsp_overlay_ff <= pend_overlay_ff;
         rsp_speed_ff   <= pend_speed_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_read_data           = rsp_data_ff;
   assign rsp_boot_overlay_active = rsp_overlay_ff;
   assign rsp_double_speed_now    = rsp_speed_ff;

endmodule

[test/banked_work_ram_io_map_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_work_ram_io_map_tb
// Self-checking bench for the banked work RAM and system register map.
// A queue of bus operations feeds a valid/ready driver. A clocked monitor
// keeps its own image of every store and register. It predicts each response
// when the request transfer happens and checks responses in order. Phases run
// under several machine modes and boot settings. Both channels idle in random
// bursts, and one phase mid-run and the last phase run flat out.
// ----------------------------------------------------------------------------
module banked_work_ram_io_map_tb;
   import bwr_pkg::*;

   localparam int WRAM_BANKS = 8;
   localparam int BANK_SIZE  = 4096;
   localparam int HRAM_SIZE  = 127;
   localparam int PHASE_OPS  = 170;
   localparam int N_PHASES   = 8;

   localparam logic [1:0] CMD_NOP       = 2'd3;
   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam logic [7:0] IR_NO_SIGNAL  = 8'h02;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_op_type;

   typedef struct packed {
      logic [7:0] rd;
      logic       overlay;
      logic       dspeed;
   } bus_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_READ;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_boot_overlay_active;
   logic        rsp_double_speed_now;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_MACHINE_MODE;
   logic [1:0]  csr_write_data = '0;

   banked_work_ram_io_map #(.RAM_BANKS(WRAM_BANKS)) DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_command             (req_command),
      .req_address             (req_address),
      .req_write_data          (req_write_data),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_read_data           (rsp_read_data),
      .rsp_boot_overlay_active (rsp_boot_overlay_active),
      .rsp_double_speed_now    (rsp_double_speed_now),
      .csr_write_en            (csr_write_en),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   always #1 clock = ~clock;

   // ---- image of the block's state ----
   logic [7:0] wram_img [0:WRAM_BANKS*BANK_SIZE-1];
   logic [7:0] hram_img [0:HRAM_SIZE-1];
   logic [7:0] spare_img [0:2];
   logic [7:0] ie_reg, boot_reg, ir_reg;
   logic [4:0] if_reg;
   logic [2:0] bank_reg, spare_hi;
   logic       armed, dspeed, prio;
   logic [1:0] mode_cfg;
   logic       skip_cfg;

   bus_op_type  bus_ops [$];
   bus_rsp_type rsp_due [$];
   bus_op_type  next_op;
   int          queued_total = 0;
   int          accepted_cnt = 0;
   int          done_cnt = 0;
   int          fail_cnt = 0;
   logic        req_fire = 1'b0;
   logic        idle_en = 1'b1;
   int          req_gap = 0;
   int          rsp_stall = 0;

   function automatic logic colour_hw();
      return mode_cfg == MODE_COLOUR || mode_cfg == MODE_COMPAT;
   endfunction

   function automatic int upper_bank();
      int b;
      if (mode_cfg != MODE_COLOUR) begin
         b = 1;
      end else begin
         b = int'(bank_reg);
         if (b == 0) b = 1;
      end
      if (b >= WRAM_BANKS) b = WRAM_BANKS - 1;
      return b;
   endfunction

   // echo region folds onto C000 by dropping address bits above 12
   function automatic int wram_slot(logic [15:0] a);
      logic [12:0] off;
      if (a < ADDR_WRAM_LO || a > ADDR_WRAM_HI) return -1;
      off = 13'(a - ADDR_WRAM_LO);
      return (off[12] ? upper_bank() : 0) * BANK_SIZE + int'(off[11:0]);
   endfunction

   function automatic logic [7:0] boot_now();
      return skip_cfg ? 8'd1 : boot_reg;
   endfunction

   function automatic logic [7:0] io_peek(logic [15:0] a);
      logic       f;
      logic [7:0] v;
      f = (mode_cfg == MODE_COLOUR);
      v = IO_OPEN_BUS;
      case (a)
         ADDR_KEY1: if (colour_hw()) v = {dspeed, 6'd0, armed} | MASK_KEY1_SET;
         ADDR_IR: if (f) begin
            v = (ir_reg & MASK_IR_KEEP) | MASK_IR_SET |
                (((ir_reg & MASK_IR_RX) == MASK_IR_RX) ? 8'h00 : IR_NO_SIGNAL);
         end
         ADDR_PRIO:   if (f) v = {7'd0, prio} | MASK_PRIO_SET;
         ADDR_BANK:   if (f) v = {5'd0, bank_reg} | MASK_BANK_SET;
         ADDR_SPARE0: if (f) v = spare_img[0];
         ADDR_SPARE1: if (f) v = spare_img[1];
         ADDR_SPARE2: if (f) v = spare_img[2];
         ADDR_SPARE3: if (f) v = {1'b0, spare_hi, 4'd0} | MASK_SPARE_SET;
         default: ;
      endcase
      return v;
   endfunction

   function automatic void io_poke(logic [15:0] a, logic [7:0] d);
      logic f;
      f = (mode_cfg == MODE_COLOUR);
      case (a)
         ADDR_KEY1:   if (colour_hw()) armed = d[0];
         ADDR_IR:     if (f) ir_reg = d;
         ADDR_PRIO:   if (f) prio = d[0];
         ADDR_BANK:   if (f) bank_reg = d[2:0];
         ADDR_SPARE0: if (f) spare_img[0] = d;
         ADDR_SPARE1: if (f) spare_img[1] = d;
         ADDR_SPARE2: if (f) spare_img[2] = d;
         ADDR_SPARE3: if (f) spare_hi = d[6:4];
         default: ;
      endcase
   endfunction

   // applies one bus operation to the image and returns the response it gives
   function automatic bus_rsp_type mem_map_access(bus_op_type op);
      bus_rsp_type r;
      int          slot;
      r = '0;
      slot = wram_slot(op.addr);
      case (op.cmd)
         CMD_READ: begin
            if (slot >= 0) r.rd = wram_img[slot];
            else if (op.addr >= ADDR_HRAM_LO && op.addr < ADDR_IE)
               r.rd = hram_img[op.addr[6:0]];
            else if (op.addr == ADDR_IE) r.rd = ie_reg;
            else if (op.addr == ADDR_IF) r.rd = {3'd0, if_reg} | MASK_IF_SET;
            else if (op.addr == ADDR_BOOT) r.rd = boot_now();
            else if (op.addr >= ADDR_IO_LO && op.addr <= ADDR_IO_HI)
               r.rd = io_peek(op.addr);
         end
         CMD_WRITE: begin
            if (slot >= 0) wram_img[slot] = op.data;
            else if (op.addr >= ADDR_HRAM_LO && op.addr < ADDR_IE)
               hram_img[op.addr[6:0]] = op.data;
            else if (op.addr == ADDR_IE) ie_reg = op.data;
            else if (op.addr == ADDR_IF) if_reg = op.data[4:0];
            else if (op.addr == ADDR_BOOT) begin
               // boot flag latches once, and only with a non-zero byte
               if (!skip_cfg && boot_reg == 8'd0 && op.data != 8'd0) boot_reg = op.data;
            end else if (op.addr >= ADDR_IO_LO && op.addr <= ADDR_IO_HI)
               io_poke(op.addr, op.data);
         end
         CMD_SPEED: begin
            dspeed = ~dspeed;
            armed  = 1'b0;
         end
         default: ;
      endcase
      r.overlay = (boot_now() == 8'd0);
      r.dspeed  = dspeed;
      return r;
   endfunction

   function automatic bus_op_type rand_op();
      bus_op_type  op;
      int          pick, h;
      logic [11:0] off;
      op.cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      pick    = $urandom_range(0, 9);
      op.data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      // a handful of hot offsets so reads find earlier writes
      h   = $urandom_range(0, 7);
      off = $urandom_range(0, 1) ? ((h == 7) ? 12'hFFF : {h[2:0], 6'd0, h[2:0]})
                                 : 12'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         op.addr = 16'hC000 | {3'd0, 1'($urandom_range(0, 1)), off};
      end else if (pick < 40) begin
         op.addr = 16'hE000 | {3'd0, 1'($urandom_range(0, 1)), off};
         if (op.addr > ADDR_WRAM_HI) op.addr = op.addr - 16'h2000;
      end else if (pick < 48) begin
         op.addr = ADDR_BANK;
         if ($urandom_range(0, 3) != 0) op.data = 8'($urandom_range(0, 7));
      end else if (pick < 56) begin
         op.addr = 16'($urandom_range(ADDR_HRAM_LO, ADDR_IE));
      end else if (pick < 76) begin
         case ($urandom_range(0, 10))
            0: op.addr = ADDR_IF;
            1: op.addr = ADDR_BOOT;
            2: op.addr = ADDR_KEY1;
            3: op.addr = ADDR_IR;
            4: op.addr = ADDR_PRIO;
            5: op.addr = ADDR_BANK;
            6: op.addr = ADDR_SPARE0;
            7: op.addr = ADDR_SPARE1;
            8: op.addr = ADDR_SPARE2;
            9: op.addr = ADDR_SPARE3;
            default: op.addr = ADDR_IO_HI;
         endcase
      end else if (pick < 84) begin
         op.addr = 16'($urandom_range(ADDR_IO_LO, ADDR_IO_HI));
      end else if (pick < 92) begin
         op.addr = 16'($urandom_range(0, 16'hFFFF));
      end else begin
         op.addr = 16'($urandom_range(0, 16'hFFFF));
         op.cmd  = (pick < 97) ? CMD_SPEED : CMD_NOP;
      end
      return op;
   endfunction

   task automatic push_op(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d);
      bus_ops.push_back({c, a, d});
      queued_total++;
   endtask

   // register write; the image follows at once since nothing is in flight
   task automatic csr_write(input logic idx, input logic [1:0] val);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      if (idx == CSR_MACHINE_MODE) begin
         mode_cfg = val;
         if (!colour_hw()) begin
            armed    = 1'b0;
            dspeed   = 1'b0;
            bank_reg = 3'd0;
         end
      end else begin
         skip_cfg = val[0];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (!(accepted_cnt == queued_total && done_cnt == queued_total))
         @(negedge clock);
      // response path is two stages deep
      repeat (4) @(negedge clock);
   endtask

   // ---- request driver ----
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (bus_ops.size() > 0) begin
            next_op        = bus_ops.pop_front();
            req_valid      <= 1'b1;
            req_command    <= next_op.cmd;
            req_address    <= next_op.addr;
            req_write_data <= next_op.data;
            if (idle_en && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---- response back-pressure ----
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         rsp_stall <= $urandom_range(1, 7) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---- monitor: predict on request transfer, check on response transfer ----
   always @(posedge clock) begin
      bus_rsp_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         done_cnt <= done_cnt + 1;
         if (rsp_due.size() == 0) begin
            fail_cnt <= fail_cnt + 1;
            if (fail_cnt < 10)
               $display("unexpected response rd=%02h ovl=%0d ds=%0d", rsp_read_data,
                        rsp_boot_overlay_active, rsp_double_speed_now);
         end else begin
            want = rsp_due.pop_front();
            if (rsp_read_data !== want.rd || rsp_boot_overlay_active !== want.overlay ||
                rsp_double_speed_now !== want.dspeed) begin
               fail_cnt <= fail_cnt + 1;
               if (fail_cnt < 10)
                  $display({"mismatch at %0t: expected rd=%02h ovl=%0d ds=%0d, ",
                            "got rd=%02h ovl=%0d ds=%0d"},
                           $realtime, want.rd, want.overlay, want.dspeed, rsp_read_data,
                           rsp_boot_overlay_active, rsp_double_speed_now);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         rsp_due.push_back(mem_map_access({req_command, req_address, req_write_data}));
         accepted_cnt <= accepted_cnt + 1;
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [1:0] ph_mode, ph_skip;
      for (int i = 0; i < WRAM_BANKS*BANK_SIZE; i++) wram_img[i] = 8'd0;
      for (int i = 0; i < HRAM_SIZE; i++) hram_img[i] = 8'd0;
      for (int i = 0; i < 3; i++) spare_img[i] = 8'd0;
      ie_reg = '0; boot_reg = '0; ir_reg = '0; if_reg = '0;
      bank_reg = '0; spare_hi = '0; armed = 1'b0; dspeed = 1'b0; prio = 1'b0;
      mode_cfg = MODE_MONO; skip_cfg = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed part in colour mode, boot ROM present
      csr_write(CSR_SKIP_BOOT, 2'd0);
      csr_write(CSR_MACHINE_MODE, MODE_COLOUR);
      @(posedge clock);
      push_op(CMD_READ,  ADDR_BOOT, 8'h00);
      push_op(CMD_WRITE, ADDR_BOOT, 8'h00);
      push_op(CMD_WRITE, ADDR_BANK, 8'h07);
      push_op(CMD_WRITE, 16'hD000,  8'hAB);
      push_op(CMD_WRITE, ADDR_BANK, 8'h00);   // zero selects bank one
      push_op(CMD_WRITE, 16'hD000,  8'h11);
      push_op(CMD_READ,  16'hF000,  8'h00);
      push_op(CMD_WRITE, ADDR_BANK, 8'hFF);
      push_op(CMD_READ,  16'hF000,  8'h00);
      push_op(CMD_WRITE, 16'hC000,  8'hFF);
      push_op(CMD_READ,  16'hE000,  8'h00);
      push_op(CMD_READ,  16'hFDFF,  8'h00);
      push_op(CMD_READ,  16'h0000,  8'hFF);
      push_op(CMD_READ,  16'hFE00,  8'h00);
      push_op(CMD_WRITE, ADDR_IO_HI, 8'h55);
      push_op(CMD_READ,  ADDR_IO_HI, 8'h00);
      push_op(CMD_WRITE, 16'hFFFE,  8'h80);
      push_op(CMD_WRITE, ADDR_IE,   8'hFF);
      push_op(CMD_WRITE, ADDR_IF,   8'hFF);
      push_op(CMD_READ,  ADDR_IF,   8'h00);
      push_op(CMD_WRITE, ADDR_KEY1, 8'hFF);
      push_op(CMD_READ,  ADDR_KEY1, 8'h00);
      push_op(CMD_SPEED, 16'hFFFF,  8'hFF);
      push_op(CMD_READ,  ADDR_KEY1, 8'h00);
      push_op(CMD_WRITE, ADDR_IR,   8'hC0);
      push_op(CMD_READ,  ADDR_IR,   8'h00);
      push_op(CMD_WRITE, ADDR_SPARE3, 8'hFF);
      push_op(CMD_READ,  ADDR_SPARE3, 8'h00);
      push_op(CMD_NOP,   ADDR_IE,   8'hFF);
      push_op(CMD_WRITE, ADDR_BOOT, 8'h5A);
      push_op(CMD_WRITE, ADDR_BOOT, 8'hFF);   // ignored, already latched
      push_op(CMD_READ,  ADDR_BOOT, 8'h00);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: begin ph_mode = MODE_COLOUR;   ph_skip = 2'd0; end
            1: begin ph_mode = MODE_MONO;     ph_skip = 2'd2; end
            2: begin ph_mode = MODE_COMPAT;   ph_skip = 2'd1; end
            3: begin ph_mode = MODE_COLOUR;   ph_skip = 2'd1; end
            4: begin ph_mode = MODE_RESERVED; ph_skip = 2'd0; end
            5: begin ph_mode = MODE_COLOUR;   ph_skip = 2'd0; end
            6: begin ph_mode = MODE_COMPAT;   ph_skip = 2'd0; end
            default: begin ph_mode = MODE_COLOUR; ph_skip = 2'd3; end
         endcase
         csr_write(CSR_MACHINE_MODE, ph_mode);
         csr_write(CSR_SKIP_BOOT, ph_skip);
         // no idle bursts in one phase mid-run nor in the last phase
         idle_en <= !(ph == 2 || ph == N_PHASES - 1);
         @(posedge clock);
         for (int i = 0; i < PHASE_OPS; i++) bus_ops.push_back(rand_op());
         queued_total += PHASE_OPS;
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_cnt == 0 && rsp_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
